// ===== sv/edl_pkg.sv =====
// Shared types, constants and helpers of the line editor.
package edl_pkg;

  localparam int CAP     = 256;
  localparam int ADDR_W  = $clog2(CAP);
  localparam int CNT_W   = $clog2(CAP + 1);
  localparam int GLYPH_W = 21;
  localparam int ACT_W   = 5;
  localparam int IDX_W   = 8;
  localparam int WIDE_W  = (CNT_W > IDX_W) ? CNT_W + 1 : IDX_W + 1;

  localparam logic [GLYPH_W-1:0] GLYPH_SPACE = GLYPH_W'(32);
  localparam logic [GLYPH_W-1:0] GLYPH_TAB   = GLYPH_W'(9);

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT      = 5'd0,
    ACT_LEFT        = 5'd1,
    ACT_RIGHT       = 5'd2,
    ACT_HOME        = 5'd3,
    ACT_END         = 5'd4,
    ACT_WORDBACK    = 5'd5,
    ACT_WORDFWD     = 5'd6,
    ACT_BACKSPACE   = 5'd7,
    ACT_DELETE      = 5'd8,
    ACT_KILLSTART   = 5'd9,
    ACT_KILLEND     = 5'd10,
    ACT_KILLWORDBK  = 5'd11,
    ACT_KILLWORDFWD = 5'd12,
    ACT_YANK        = 5'd13,
    ACT_IGNORE      = 5'd14,
    ACT_BEEPKEY     = 5'd15,
    ACT_READLINE    = 5'd16,
    ACT_READKILL    = 5'd17
  } act_t;

  typedef enum logic [2:0] {
    CMD_HOLD, CMD_PUSH, CMD_POP, CMD_ROT, CMD_ROTN, CMD_PUTAT
  } chain_cmd_t;

  typedef enum logic [2:0] {
    SRC_HOLD, SRC_PREV, SRC_NEXT, SRC_HEAD, SRC_DIN
  } cell_src_t;

  typedef enum logic [1:0] {
    RSEL_LEFT, RSEL_RIGHT, RSEL_KILL
  } rsel_t;

  typedef enum logic [4:0] {
    S_IDLE, S_EXEC, S_HOME, S_END, S_WB1, S_WB2, S_WF1, S_WF2,
    S_KSTART, S_KEND, S_KWB1, S_KWB2, S_KWF1, S_KWF2, S_YANK, S_READ, S_DONE
  } state_t;

  typedef struct packed {
    chain_cmd_t         cmd;
    logic [CNT_W-1:0]   pos;
    logic [GLYPH_W-1:0] din;
  } chain_ctl_t;

  function automatic logic is_gap(input logic [GLYPH_W-1:0] g);
    is_gap = (g == GLYPH_SPACE) || (g == GLYPH_TAB);
  endfunction

endpackage

// ===== sv/edl_if.sv =====
// Request and result channel interfaces of the line editor.
interface edl_in_if;
  import edl_pkg::*;
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [GLYPH_W-1:0] glyph;
  logic [IDX_W-1:0]   index;
  modport source(output valid, action, glyph, index, input ready);
  modport sink(input valid, action, glyph, index, output ready);
endinterface

interface edl_out_if;
  import edl_pkg::*;
  logic               valid;
  logic               ready;
  logic               beep;
  logic [CNT_W-1:0]   cursor_pos;
  logic [CNT_W-1:0]   line_length;
  logic [CNT_W-1:0]   kill_length;
  logic [GLYPH_W-1:0] read_glyph;
  modport source(output valid, beep, cursor_pos, line_length, kill_length, read_glyph,
                 input ready);
  modport sink(input valid, beep, cursor_pos, line_length, kill_length, read_glyph,
               output ready);
endinterface

// ===== sv/edl_cell.sv =====
// One glyph cell of a chain: a register that loads from a neighbour, the head cell or the feed.
module edl_cell (
  input  logic                        clk,
  input  edl_pkg::cell_src_t          src,
  input  logic [edl_pkg::GLYPH_W-1:0] prev_val,
  input  logic [edl_pkg::GLYPH_W-1:0] next_val,
  input  logic [edl_pkg::GLYPH_W-1:0] head_val,
  input  logic [edl_pkg::GLYPH_W-1:0] din,
  output logic [edl_pkg::GLYPH_W-1:0] val
);
  import edl_pkg::*;

  logic [GLYPH_W-1:0] val_r;

  // load the selected source
  always_ff @(posedge clk) begin
    case (src)
      SRC_PREV: val_r <= prev_val;
      SRC_NEXT: val_r <= next_val;
      SRC_HEAD: val_r <= head_val;
      SRC_DIN:  val_r <= din;
      default:  val_r <= val_r;
    endcase
  end

  assign val = val_r;
endmodule

// ===== sv/edl_chain.sv =====
// Row of glyph cells acting as stack, ring or append queue.
module edl_chain (
  input  logic                        clk,
  input  edl_pkg::chain_ctl_t         ctl,
  output logic [edl_pkg::GLYPH_W-1:0] head
);
  import edl_pkg::*;

  logic [GLYPH_W-1:0] val [CAP];
  cell_src_t          src [CAP];

  assign head = val[0];

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX  = CNT_W'(i);
    localparam logic [CNT_W:0]   IDX1 = (CNT_W + 1)'(i + 1);
    logic [GLYPH_W-1:0] prev_v;
    logic [GLYPH_W-1:0] next_v;

    if (i == 0) begin : g_first
      assign prev_v = ctl.din;
    end else begin : g_mid
      assign prev_v = val[i-1];
    end
    if (i == CAP - 1) begin : g_last
      assign next_v = val[0];
    end else begin : g_inner
      assign next_v = val[i+1];
    end

    // pick the source of this cell for the current command
    always_comb begin
      src[i] = SRC_HOLD;
      case (ctl.cmd)
        CMD_PUSH:  src[i] = (i == 0) ? SRC_DIN : SRC_PREV;
        CMD_POP:   src[i] = (i == CAP - 1) ? SRC_HOLD : SRC_NEXT;
        CMD_ROT:   src[i] = (i == CAP - 1) ? SRC_HEAD : SRC_NEXT;
        CMD_ROTN: begin
          if (IDX1 < {1'b0, ctl.pos}) src[i] = SRC_NEXT;
          else if (IDX1 == {1'b0, ctl.pos}) src[i] = SRC_HEAD;
        end
        CMD_PUTAT: src[i] = (IDX == ctl.pos) ? SRC_DIN : SRC_HOLD;
        default:   src[i] = SRC_HOLD;
      endcase
    end

    edl_cell u_cell (
      .clk      (clk),
      .src      (src[i]),
      .prev_val (prev_v),
      .next_val (next_v),
      .head_val (val[0]),
      .din      (ctl.din),
      .val      (val[i])
    );
  end
endmodule

// ===== sv/line_editor_with_kill_buffer.sv =====
// Top level of the line editor: gap-style cell chains plus edit sequencer.
//
//   channel | dir | handshake     | payload
//   in_ch   | in  | valid / ready | action, glyph, index
//   out_ch  | out | valid / ready | beep, cursor_pos, line_length, kill_length, read_glyph
//
// The line is held as two cell chains split at the cursor (left part top-first,
// right part top-first); the kill store is a third chain.
// A request is accepted, executed and its result registered; moves, pops and
// yanks step glyph by glyph, and word actions scan first over gaps, then over
// the word. Reads rotate one chain through all CAP cells.
// Reset clears cursor, length, kill count and the kill-run flag at once.
// A new request is taken once the sequencer is idle; a stalled result holds
// the sequencer in its final state until the result register frees.
module line_editor_with_kill_buffer (
  input logic    clk,
  input logic    rst_n,
  edl_in_if.sink    in_ch,
  edl_out_if.source out_ch
);
  import edl_pkg::*;

  state_t             state_r, state_nxt;
  logic [ACT_W-1:0]   act_r, act_nxt;
  logic [GLYPH_W-1:0] glyph_r, glyph_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   cursor_r, cursor_nxt;
  logic [CNT_W-1:0]   len_r, len_nxt;
  logic [CNT_W-1:0]   kcnt_r, kcnt_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]  tgt_r, tgt_nxt;
  rsel_t              rsel_r, rsel_nxt;
  logic               killed_r, killed_nxt;
  logic               last_gap_r, last_gap_nxt;
  logic               beep_r, beep_nxt;
  logic [GLYPH_W-1:0] rd_r, rd_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               o_beep_r, o_beep_nxt;
  logic [CNT_W-1:0]   o_cur_r, o_cur_nxt;
  logic [CNT_W-1:0]   o_len_r, o_len_nxt;
  logic [CNT_W-1:0]   o_kcnt_r, o_kcnt_nxt;
  logic [GLYPH_W-1:0] o_rd_r, o_rd_nxt;

  chain_ctl_t         lctl, rctl, kctl;
  logic [GLYPH_W-1:0] lhead, rhead, khead, rot_head;
  logic               in_fire;
  logic               c_nz, r_nz;
  logic [WIDE_W-1:0]  idx_w;

  edl_chain u_left  (.clk(clk), .ctl(lctl), .head(lhead));
  edl_chain u_right (.clk(clk), .ctl(rctl), .head(rhead));
  edl_chain u_kill  (.clk(clk), .ctl(kctl), .head(khead));

  assign in_ch.ready        = (state_r == S_IDLE);
  assign in_fire            = in_ch.valid && in_ch.ready;
  assign c_nz               = (cursor_r != '0);
  assign r_nz               = (len_r > cursor_r);
  assign idx_w              = WIDE_W'(idx_r);
  assign rot_head           = (rsel_r == RSEL_LEFT) ? lhead :
                              (rsel_r == RSEL_RIGHT) ? rhead : khead;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.beep        = o_beep_r;
  assign out_ch.cursor_pos  = o_cur_r;
  assign out_ch.line_length = o_len_r;
  assign out_ch.kill_length = o_kcnt_r;
  assign out_ch.read_glyph  = o_rd_r;

  // hold state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_r    <= '0;
      len_r       <= '0;
      kcnt_r      <= '0;
      killed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      len_r       <= len_nxt;
      kcnt_r      <= kcnt_nxt;
      killed_r    <= killed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold request and result payload
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    glyph_r    <= glyph_nxt;
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    tgt_r      <= tgt_nxt;
    rsel_r     <= rsel_nxt;
    last_gap_r <= last_gap_nxt;
    beep_r     <= beep_nxt;
    rd_r       <= rd_nxt;
    o_beep_r   <= o_beep_nxt;
    o_cur_r    <= o_cur_nxt;
    o_len_r    <= o_len_nxt;
    o_kcnt_r   <= o_kcnt_nxt;
    o_rd_r     <= o_rd_nxt;
  end

  // sequence each request over the chains
  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    glyph_nxt     = glyph_r;
    idx_nxt       = idx_r;
    cursor_nxt    = cursor_r;
    len_nxt       = len_r;
    kcnt_nxt      = kcnt_r;
    cnt_nxt       = cnt_r;
    tgt_nxt       = tgt_r;
    rsel_nxt      = rsel_r;
    killed_nxt    = killed_r;
    last_gap_nxt  = last_gap_r;
    beep_nxt      = beep_r;
    rd_nxt        = rd_r;
    out_valid_nxt = out_valid_r;
    o_beep_nxt    = o_beep_r;
    o_cur_nxt     = o_cur_r;
    o_len_nxt     = o_len_r;
    o_kcnt_nxt    = o_kcnt_r;
    o_rd_nxt      = o_rd_r;
    lctl          = '{cmd: CMD_HOLD, pos: '0, din: '0};
    rctl          = '{cmd: CMD_HOLD, pos: '0, din: '0};
    kctl          = '{cmd: CMD_HOLD, pos: '0, din: '0};

    // drop the result once taken
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          act_nxt   = in_ch.action;
          glyph_nxt = in_ch.glyph;
          idx_nxt   = in_ch.index;
          beep_nxt  = 1'b0;
          rd_nxt    = '0;
          if (!(in_ch.action inside {ACT_READLINE, ACT_READKILL})) begin
            killed_nxt = in_ch.action inside {[ACT_KILLSTART:ACT_KILLWORDFWD]};
            if ((in_ch.action inside {[ACT_KILLSTART:ACT_KILLWORDFWD]}) && !killed_r)
              kcnt_nxt = '0;
          end
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_DONE;
        case (act_r)
          ACT_INSERT: begin
            if (len_r == CNT_W'(CAP)) beep_nxt = 1'b1;
            else begin
              lctl.cmd   = CMD_PUSH;
              lctl.din   = glyph_r;
              cursor_nxt = cursor_r + 1'b1;
              len_nxt    = len_r + 1'b1;
            end
          end
          ACT_LEFT: begin
            if (c_nz) begin
              lctl.cmd   = CMD_POP;
              rctl.cmd   = CMD_PUSH;
              rctl.din   = lhead;
              cursor_nxt = cursor_r - 1'b1;
            end else beep_nxt = 1'b1;
          end
          ACT_RIGHT: begin
            if (r_nz) begin
              rctl.cmd   = CMD_POP;
              lctl.cmd   = CMD_PUSH;
              lctl.din   = rhead;
              cursor_nxt = cursor_r + 1'b1;
            end else beep_nxt = 1'b1;
          end
          ACT_HOME: state_nxt = S_HOME;
          ACT_END:  state_nxt = S_END;
          ACT_WORDBACK: begin
            if (c_nz) begin
              lctl.cmd     = CMD_POP;
              rctl.cmd     = CMD_PUSH;
              rctl.din     = lhead;
              last_gap_nxt = is_gap(lhead);
              cursor_nxt   = cursor_r - 1'b1;
              state_nxt    = S_WB1;
            end else beep_nxt = 1'b1;
          end
          ACT_WORDFWD: begin
            if (r_nz) begin
              rctl.cmd   = CMD_POP;
              lctl.cmd   = CMD_PUSH;
              lctl.din   = rhead;
              cursor_nxt = cursor_r + 1'b1;
              state_nxt  = S_WF1;
            end else beep_nxt = 1'b1;
          end
          ACT_BACKSPACE: begin
            if (c_nz) begin
              lctl.cmd   = CMD_POP;
              cursor_nxt = cursor_r - 1'b1;
              len_nxt    = len_r - 1'b1;
            end
          end
          ACT_DELETE: begin
            if (r_nz) begin
              rctl.cmd = CMD_POP;
              len_nxt  = len_r - 1'b1;
            end else beep_nxt = 1'b1;
          end
          ACT_KILLSTART: state_nxt = S_KSTART;
          ACT_KILLEND:   state_nxt = S_KEND;
          ACT_KILLWORDBK: begin
            if (c_nz) begin
              lctl.cmd     = CMD_POP;
              kctl.cmd     = CMD_PUSH;
              kctl.din     = lhead;
              last_gap_nxt = is_gap(lhead);
              cursor_nxt   = cursor_r - 1'b1;
              len_nxt      = len_r - 1'b1;
              kcnt_nxt     = kcnt_r + 1'b1;
              state_nxt    = S_KWB1;
            end
          end
          ACT_KILLWORDFWD: begin
            if (r_nz) begin
              rctl.cmd  = CMD_POP;
              kctl.cmd  = CMD_PUTAT;
              kctl.pos  = kcnt_r;
              kctl.din  = rhead;
              len_nxt   = len_r - 1'b1;
              kcnt_nxt  = kcnt_r + 1'b1;
              state_nxt = S_KWF1;
            end
          end
          ACT_YANK: begin
            if (({1'b0, len_r} + {1'b0, kcnt_r}) > (CNT_W + 1)'(CAP)) beep_nxt = 1'b1;
            else begin
              cnt_nxt   = '0;
              state_nxt = S_YANK;
            end
          end
          ACT_BEEPKEY: beep_nxt = 1'b1;
          ACT_READLINE: begin
            if (idx_w < WIDE_W'(len_r)) begin
              cnt_nxt   = '0;
              state_nxt = S_READ;
              if (idx_w < WIDE_W'(cursor_r)) begin
                rsel_nxt = RSEL_LEFT;
                tgt_nxt  = ADDR_W'(WIDE_W'(cursor_r) - idx_w - 1'b1);
              end else begin
                rsel_nxt = RSEL_RIGHT;
                tgt_nxt  = ADDR_W'(idx_w - WIDE_W'(cursor_r));
              end
            end
          end
          ACT_READKILL: begin
            if (idx_w < WIDE_W'(kcnt_r)) begin
              cnt_nxt   = '0;
              rsel_nxt  = RSEL_KILL;
              tgt_nxt   = ADDR_W'(idx_w);
              state_nxt = S_READ;
            end
          end
          default: ;
        endcase
      end

      // move the cursor one glyph a cycle
      S_HOME: begin
        if (c_nz) begin
          lctl.cmd   = CMD_POP;
          rctl.cmd   = CMD_PUSH;
          rctl.din   = lhead;
          cursor_nxt = cursor_r - 1'b1;
        end else state_nxt = S_DONE;
      end
      S_END: begin
        if (r_nz) begin
          rctl.cmd   = CMD_POP;
          lctl.cmd   = CMD_PUSH;
          lctl.din   = rhead;
          cursor_nxt = cursor_r + 1'b1;
        end else state_nxt = S_DONE;
      end
      S_WB1, S_WB2: begin
        if (c_nz && ((state_r == S_WB1) ? last_gap_r : !is_gap(lhead))) begin
          lctl.cmd     = CMD_POP;
          rctl.cmd     = CMD_PUSH;
          rctl.din     = lhead;
          last_gap_nxt = is_gap(lhead);
          cursor_nxt   = cursor_r - 1'b1;
        end else state_nxt = (state_r == S_WB1) ? S_WB2 : S_DONE;
      end
      S_WF1, S_WF2: begin
        if (r_nz && ((state_r == S_WF1) ? is_gap(rhead) : !is_gap(rhead))) begin
          rctl.cmd   = CMD_POP;
          lctl.cmd   = CMD_PUSH;
          lctl.din   = rhead;
          cursor_nxt = cursor_r + 1'b1;
        end else state_nxt = (state_r == S_WF1) ? S_WF2 : S_DONE;
      end

      // move killed glyphs into the kill chain
      S_KSTART, S_KWB1, S_KWB2: begin
        if (c_nz && ((state_r == S_KSTART) ||
                     ((state_r == S_KWB1) ? last_gap_r : !is_gap(lhead)))) begin
          lctl.cmd     = CMD_POP;
          kctl.cmd     = CMD_PUSH;
          kctl.din     = lhead;
          last_gap_nxt = is_gap(lhead);
          cursor_nxt   = cursor_r - 1'b1;
          len_nxt      = len_r - 1'b1;
          kcnt_nxt     = kcnt_r + 1'b1;
        end else state_nxt = (state_r == S_KWB1) ? S_KWB2 : S_DONE;
      end
      S_KEND, S_KWF1, S_KWF2: begin
        if (r_nz && ((state_r == S_KEND) ||
                     ((state_r == S_KWF1) ? is_gap(rhead) : !is_gap(rhead)))) begin
          rctl.cmd = CMD_POP;
          kctl.cmd = CMD_PUTAT;
          kctl.pos = kcnt_r;
          kctl.din = rhead;
          len_nxt  = len_r - 1'b1;
          kcnt_nxt = kcnt_r + 1'b1;
        end else state_nxt = (state_r == S_KWF1) ? S_KWF2 : S_DONE;
      end

      // push the kill text while rotating it back into place
      S_YANK: begin
        if (cnt_r != kcnt_r) begin
          lctl.cmd   = CMD_PUSH;
          lctl.din   = khead;
          kctl.cmd   = CMD_ROTN;
          kctl.pos   = kcnt_r;
          cursor_nxt = cursor_r + 1'b1;
          len_nxt    = len_r + 1'b1;
          cnt_nxt    = cnt_r + 1'b1;
        end else state_nxt = S_DONE;
      end

      // rotate the chosen chain once round, catching the target glyph
      S_READ: begin
        case (rsel_r)
          RSEL_LEFT:  lctl.cmd = CMD_ROT;
          RSEL_RIGHT: rctl.cmd = CMD_ROT;
          default:    kctl.cmd = CMD_ROT;
        endcase
        if (cnt_r[ADDR_W-1:0] == tgt_r) rd_nxt = rot_head;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CAP - 1)) state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_beep_nxt    = beep_r;
          o_cur_nxt     = cursor_r;
          o_len_nxt     = len_r;
          o_kcnt_nxt    = kcnt_r;
          o_rd_nxt      = rd_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= len_r)
    else $error("cursor beyond end of line");

  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r <= CNT_W'(CAP)) && (kcnt_r <= CNT_W'(CAP)))
    else $error("line or kill count beyond capacity");

  a_read_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> $stable(len_r) && $stable(cursor_r) && $stable(kcnt_r))
    else $error("read changed editor state");
`endif

endmodule
